[rtl/core/rgbfb_pkg.sv]
`default_nettype none

package rgbfb_pkg;

  // Side of the square ordered-dither threshold table.
  localparam int unsigned DITHER_DIM = 16;
  localparam int unsigned PHASE_W    = $clog2(DITHER_DIM);

  // Widths of the configuration write channel.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  // Width of the packed framebuffer word.
  localparam int unsigned WORD_W = 32;

  // Pixel size that selects dithered RGB565.
  localparam logic [2:0] BPP_RGB565 = 3'd2;
  localparam logic [2:0] BPP_ONE    = 3'd1;
  localparam logic [2:0] BPP_THREE  = 3'd3;
  localparam logic [2:0] BPP_FOUR   = 3'd4;

  // Largest number of bits that a channel can contribute.
  localparam logic [3:0] CHAN_BITS = 4'd8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_BYTES     = 3'd0,
    CFG_RED_SIZE        = 3'd1,
    CFG_RED_SHIFT       = 3'd2,
    CFG_GREEN_SIZE      = 3'd3,
    CFG_GREEN_SHIFT     = 3'd4,
    CFG_BLUE_SIZE       = 3'd5,
    CFG_BLUE_SHIFT      = 3'd6
  } rgbfb_cfg_idx_t;

  // Source pixel as it travels through the pipeline.
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [PHASE_W-1:0] row_phase;
    logic [PHASE_W-1:0] column_phase;
  } rgbfb_pix_t;

  // Current configuration as seen by the packing logic.
  typedef struct packed {
    logic [2:0] pixel_bytes;
    logic [3:0] red_size;
    logic [4:0] red_shift;
    logic [3:0] green_size;
    logic [4:0] green_shift;
    logic [3:0] blue_size;
    logic [4:0] blue_shift;
  } rgbfb_cfg_t;

  // The 16x16 threshold table is the recursive Bayer matrix. Each level of
  // the recursion adds two bits: the upper one is the row bit XOR the column
  // bit and the lower one is the column bit, with the lowest phase bits
  // giving the most significant threshold bits.
  function automatic logic [7:0] dither_threshold(input logic [PHASE_W-1:0] row,
                                                  input logic [PHASE_W-1:0] col);
    logic [7:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      v[7-2*i] = row[i] ^ col[i];
      v[6-2*i] = col[i];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rgbfb_if.sv]
`default_nettype none

// Channel that carries one source pixel per word.
interface rgbfb_pix_if;
  logic                                valid;
  logic                                ready;
  logic [7:0]                          red;
  logic [7:0]                          green;
  logic [7:0]                          blue;
  logic [rgbfb_pkg::PHASE_W-1:0]       row_phase;
  logic [rgbfb_pkg::PHASE_W-1:0]       column_phase;

  modport source (output valid, red, green, blue, row_phase, column_phase,
                  input ready);
  modport sink (input valid, red, green, blue, row_phase, column_phase,
                output ready);
endinterface

// Channel that carries one packed framebuffer word per word.
interface rgbfb_word_if;
  logic                           valid;
  logic                           ready;
  logic [rgbfb_pkg::WORD_W-1:0]   pixel_word;

  modport source (output valid, pixel_word, input ready);
  modport sink (input valid, pixel_word, output ready);
endinterface

// Configuration register write channel.
interface rgbfb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rgbfb_pkg::CFG_IDX_W-1:0]    index;
  logic [rgbfb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/rgbfb_cfg_regs.sv]
`default_nettype none

module rgbfb_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rgbfb_cfg_if.sink          cfg_wr,
  output rgbfb_pkg::rgbfb_cfg_t cfg
);

  rgbfb_pkg::rgbfb_cfg_t cfg_r;
  rgbfb_pkg::rgbfb_cfg_t cfg_nxt;

  // Writes are always taken at once.
  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  // Decode the register index; an index past the list is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        rgbfb_pkg::CFG_PIXEL_BYTES:     cfg_nxt.pixel_bytes     = cfg_wr.data[2:0];
        rgbfb_pkg::CFG_RED_SIZE:        cfg_nxt.red_size        = cfg_wr.data[3:0];
        rgbfb_pkg::CFG_RED_SHIFT:       cfg_nxt.red_shift       = cfg_wr.data[4:0];
        rgbfb_pkg::CFG_GREEN_SIZE:      cfg_nxt.green_size      = cfg_wr.data[3:0];
        rgbfb_pkg::CFG_GREEN_SHIFT:     cfg_nxt.green_shift     = cfg_wr.data[4:0];
        rgbfb_pkg::CFG_BLUE_SIZE:       cfg_nxt.blue_size       = cfg_wr.data[3:0];
        rgbfb_pkg::CFG_BLUE_SHIFT:      cfg_nxt.blue_shift      = cfg_wr.data[4:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Reset loads the RGB565 layout.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_bytes     <= rgbfb_pkg::BPP_RGB565;
      cfg_r.red_size        <= 4'd5;
      cfg_r.red_shift       <= 5'd11;
      cfg_r.green_size      <= 4'd6;
      cfg_r.green_shift     <= 5'd5;
      cfg_r.blue_size       <= 4'd5;
      cfg_r.blue_shift      <= 5'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rgbfb_pack.sv]
`default_nettype none

module rgbfb_pack (
  input  wire rgbfb_pkg::rgbfb_pix_t    pix,
  input  wire rgbfb_pkg::rgbfb_cfg_t    cfg,
  output logic [rgbfb_pkg::WORD_W-1:0]  pixel_word
);

  // Keep the top size bits of a channel and move them to the given shift.
  // Sizes above eight keep the whole channel; bits past the word top drop.
  function automatic logic [rgbfb_pkg::WORD_W-1:0] place_field(input logic [7:0] chan,
                                                             input logic [3:0] size,
                                                             input logic [4:0] shift);
    logic [3:0]                  size_eff;
    logic [rgbfb_pkg::WORD_W-1:0] top;
    size_eff = (size > rgbfb_pkg::CHAN_BITS) ? rgbfb_pkg::CHAN_BITS : size;
    top      = rgbfb_pkg::WORD_W'(chan) >> (rgbfb_pkg::CHAN_BITS - size_eff);
    if (size_eff == 4'd0) begin
      return '0;
    end
    return top << shift;
  endfunction

  logic [7:0]                  thresh;
  logic [8:0]                  red_sum;
  logic [8:0]                  green_sum;
  logic [8:0]                  blue_sum;
  logic [7:0]                  red_sat;
  logic [7:0]                  green_sat;
  logic [7:0]                  blue_sat;
  logic [15:0]                 rgb565;
  logic [rgbfb_pkg::WORD_W-1:0] generic;

  // Ordered dither: add the scaled threshold and saturate each channel.
  assign thresh    = rgbfb_pkg::dither_threshold(pix.row_phase, pix.column_phase);
  assign red_sum   = {1'b0, pix.red}   + 9'(thresh[7:5]);
  assign green_sum = {1'b0, pix.green} + 9'(thresh[7:6]);
  assign blue_sum  = {1'b0, pix.blue}  + 9'(thresh[7:5]);
  assign red_sat   = red_sum[8]   ? 8'hff : red_sum[7:0];
  assign green_sat = green_sum[8] ? 8'hff : green_sum[7:0];
  assign blue_sat  = blue_sum[8]  ? 8'hff : blue_sum[7:0];
  assign rgb565    = {red_sat[7:3], green_sat[7:2], blue_sat[7:3]};

  // Generic packing merges the three placed fields.
  assign generic = place_field(pix.red, cfg.red_size, cfg.red_shift)
                 | place_field(pix.green, cfg.green_size, cfg.green_shift)
                 | place_field(pix.blue, cfg.blue_size, cfg.blue_shift);

  // Select the layout and clear the bits above the pixel size.
  always_comb begin
    unique case (cfg.pixel_bytes)
      rgbfb_pkg::BPP_RGB565: pixel_word = rgbfb_pkg::WORD_W'(rgb565);
      rgbfb_pkg::BPP_ONE:    pixel_word = rgbfb_pkg::WORD_W'(generic[7:0]);
      rgbfb_pkg::BPP_THREE:  pixel_word = rgbfb_pkg::WORD_W'(generic[23:0]);
      rgbfb_pkg::BPP_FOUR:   pixel_word = generic;
      default:               pixel_word = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/rgb888_to_framebuffer_pixel_core.sv]
// Converts a stream of 8-bit RGB pixels into framebuffer words, one word per
// clock while out_word is not stalled. Each accepted pixel is captured in
// the input register, packed by combinational logic and loaded into the
// result register, which offers its word; a stalled output holds its word
// while one more pixel is still taken. With a pixel size of two bytes the
// pixel is dithered with a 16x16 Bayer matrix indexed by row_phase and
// column_phase and packed as RGB565; sizes one, three and four place the top
// bits of each channel at the configured shifts. Write configuration only
// while no pixel is in flight.
`default_nettype none

module rgb888_to_framebuffer_pixel_core (
  input  wire logic     clk,
  input  wire logic     rst_n,
  rgbfb_pix_if.sink     in_pix,
  rgbfb_word_if.source  out_word,
  rgbfb_cfg_if.sink     cfg_wr
);

  rgbfb_pkg::rgbfb_cfg_t         cfg;
  rgbfb_pkg::rgbfb_pix_t         in_data;
  rgbfb_pkg::rgbfb_pix_t         s1_pix_r;
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [rgbfb_pkg::WORD_W-1:0]  out_word_r;
  logic [rgbfb_pkg::WORD_W-1:0]  pack_word;
  logic                          out_adv;
  logic                          s1_adv;

  rgbfb_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  rgbfb_pack u_pack (
    .pix        (s1_pix_r),
    .cfg        (cfg),
    .pixel_word (pack_word)
  );

  // Gather the input fields into one word.
  assign in_data.red          = in_pix.red;
  assign in_data.green        = in_pix.green;
  assign in_data.blue         = in_pix.blue;
  assign in_data.row_phase    = in_pix.row_phase;
  assign in_data.column_phase = in_pix.column_phase;

  // Each stage moves on when the stage after it is empty or draining.
  assign out_adv      = !out_valid_r || out_word.ready;
  assign s1_adv       = !s1_valid_r || out_adv;
  assign in_pix.ready = s1_adv;

  assign s1_valid_nxt  = s1_adv  ? in_pix.valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r   : out_valid_r;

  assign out_word.valid      = out_valid_r;
  assign out_word.pixel_word = out_word_r;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input and result registers load only when their stage advances.
  always_ff @(posedge clk) begin
    if (in_pix.valid && s1_adv) begin
      s1_pix_r <= in_data;
    end
    if (s1_valid_r && out_adv) begin
      out_word_r <= pack_word;
    end
  end

endmodule

`default_nettype wire
